[hdl/stoi_pkg.sv]
// shared types, constants and helpers for the string to integer parser
// used by every module of the block; depends on nothing
`default_nettype none

package stoi_pkg;

   localparam int VALUE_WIDTH    = 64;
   localparam int COUNT_WIDTH    = 16;
   localparam int OUT_VALUE_W    = 64;
   localparam int CONSUMED_W     = 16;
   localparam int STATUS_W       = 2;
   localparam int BASE_W         = 6;
   localparam int CHAR_W         = 8;
   localparam int RSP_FIELDS_W   = OUT_VALUE_W + CONSUMED_W + STATUS_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   // register indexes
   localparam logic REG_BASE_SELECT = 1'b0;
   localparam logic REG_SIGNED_MODE = 1'b1;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

   typedef struct packed {
      logic [BASE_W-1:0] base_select;
      logic              signed_mode;
   } cfg_type;

   typedef struct packed {
      logic              is_space;
      logic              is_plus;
      logic              is_minus;
      logic              is_zero;
      logic              is_x;
      logic              digit_ok;
      logic [BASE_W-1:0] digit_val;
   } char_class_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [CONSUMED_W-1:0]  consumed_count;
      logic [OUT_VALUE_W-1:0] value_bits;
   } result_type;

   function automatic logic base_ok(input logic [BASE_W-1:0] b);
      return (b == BASE_AUTO) || ((b >= BASE_MIN) && (b <= BASE_MAX));
   endfunction

endpackage

`default_nettype wire

[hdl/stoi_char_class.sv]
// character classifier: whitespace, sign, prefix letters and digit value
// depends on stoi_pkg
`default_nettype none

module stoi_char_class (
   input  wire logic [stoi_pkg::CHAR_W-1:0] char_code,
   output stoi_pkg::char_class_type         char_class
);

   logic [stoi_pkg::CHAR_W-1:0] ofs_num;
   logic [stoi_pkg::CHAR_W-1:0] ofs_upper;
   logic [stoi_pkg::CHAR_W-1:0] ofs_lower;

   assign ofs_num   = char_code - stoi_pkg::CH_ZERO;
   assign ofs_upper = char_code - stoi_pkg::CH_UPPER_A + stoi_pkg::LETTER_OFS;
   assign ofs_lower = char_code - stoi_pkg::CH_LOWER_A + stoi_pkg::LETTER_OFS;

   always_comb begin
      char_class.is_space = (char_code == stoi_pkg::CH_SPACE) ||
                            ((char_code >= stoi_pkg::CH_TAB) &&
                             (char_code <= stoi_pkg::CH_CR));
      char_class.is_plus  = (char_code == stoi_pkg::CH_PLUS);
      char_class.is_minus = (char_code == stoi_pkg::CH_MINUS);
      char_class.is_zero  = (char_code == stoi_pkg::CH_ZERO);
      char_class.is_x     = (char_code == stoi_pkg::CH_LOWER_X) ||
                            (char_code == stoi_pkg::CH_UPPER_X);
      priority if ((char_code >= stoi_pkg::CH_ZERO) && (char_code <= stoi_pkg::CH_NINE)) begin
         char_class.digit_ok  = 1'b1;
         char_class.digit_val = ofs_num[stoi_pkg::BASE_W-1:0];
      end else if ((char_code >= stoi_pkg::CH_LOWER_A) &&
                   (char_code <= stoi_pkg::CH_LOWER_Z)) begin
         char_class.digit_ok  = 1'b1;
         char_class.digit_val = ofs_lower[stoi_pkg::BASE_W-1:0];
      end else if ((char_code >= stoi_pkg::CH_UPPER_A) &&
                   (char_code <= stoi_pkg::CH_UPPER_Z)) begin
         char_class.digit_ok  = 1'b1;
         char_class.digit_val = ofs_upper[stoi_pkg::BASE_W-1:0];
      end else begin
         char_class.digit_ok  = 1'b0;
         char_class.digit_val = '0;
      end
   end

endmodule

`default_nettype wire

[hdl/stoi_parse_core.sv]
// parse state and horner accumulator, one character per step
// depends on stoi_pkg and stoi_char_class
`default_nettype none

module stoi_parse_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [stoi_pkg::CHAR_W-1:0] char_code,
   input  wire logic                        last_char,
   input  stoi_pkg::cfg_type                cfg,
   output stoi_pkg::result_type             result
);

   localparam int VW     = stoi_pkg::VALUE_WIDTH;
   localparam int CW     = stoi_pkg::COUNT_WIDTH;
   localparam int BW     = stoi_pkg::BASE_W;
   localparam int PROD_W = VW + BW + 1;
   localparam logic [VW-1:0] VMASK = {VW{1'b1}};
   localparam logic [VW-1:0] SMAX  = VMASK >> 1;
   localparam logic [CW-1:0] CMAX  = {CW{1'b1}};

   typedef enum logic [2:0] {
      PH_SPACE, PH_PREFIX, PH_ZERO, PH_XPEND, PH_DIGITS, PH_STOP
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic           neg_ff, neg_in;
   logic [BW-1:0]  base_ff, base_in;
   logic [VW-1:0]  acc_ff, acc_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  stop_ff, stop_in;

   stoi_pkg::char_class_type cls;
   logic                     prefix_path;
   logic                     take;
   logic [BW-1:0]            tbase;
   logic [PROD_W-1:0]        prod;
   logic [VW-1:0]            limit;
   logic [VW-1:0]            value;
   logic                     bs_ok;

   stoi_char_class u_class (
      .char_code  (char_code),
      .char_class (cls)
   );

   assign bs_ok = stoi_pkg::base_ok(cfg.base_select);

   always_comb begin
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      base_in     = base_ff;
      stop_in     = stop_ff;
      prefix_path = 1'b0;
      take        = 1'b0;
      tbase       = base_ff;
      count_in    = (count_ff != CMAX) ? count_ff + 1'b1 : count_ff;

      unique case (phase_ff)
         PH_SPACE: begin
            if (cls.is_space) begin
               phase_in = PH_SPACE;
            end else if (cls.is_plus || cls.is_minus) begin
               neg_in   = cls.is_minus;
               phase_in = PH_PREFIX;
            end else begin
               prefix_path = 1'b1;
            end
         end
         PH_PREFIX: begin
            prefix_path = 1'b1;
         end
         PH_ZERO: begin
            if (cls.is_x) begin
               base_in  = stoi_pkg::BASE_HEX;
               phase_in = PH_XPEND;
            end else begin
               take = 1'b1;
            end
         end
         PH_XPEND, PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (prefix_path) begin
         priority if (!bs_ok) begin
            phase_in = PH_STOP;
         end else if (((cfg.base_select == stoi_pkg::BASE_AUTO) ||
                       (cfg.base_select == stoi_pkg::BASE_HEX)) && cls.is_zero) begin
            base_in  = (cfg.base_select == stoi_pkg::BASE_HEX) ? stoi_pkg::BASE_HEX
                                                               : stoi_pkg::BASE_OCT;
            stop_in  = count_in;
            phase_in = PH_ZERO;
         end else begin
            base_in = (cfg.base_select == stoi_pkg::BASE_AUTO) ? stoi_pkg::BASE_DEC
                                                               : cfg.base_select;
            tbase   = base_in;
            take    = 1'b1;
         end
      end
   end

   // horner step with overflow test: acc*b + d > limit
   always_comb begin
      if (cfg.signed_mode) begin
         limit = neg_in ? SMAX + 1'b1 : SMAX;
      end else begin
         limit = VMASK;
      end
      prod   = PROD_W'(acc_ff) * PROD_W'(tbase) + PROD_W'(cls.digit_val);
      acc_in = acc_ff;
      ovf_in = ovf_ff;
   end

   phase_type     phase_nx;
   logic [CW-1:0] stop_nx;
   logic [VW-1:0] acc_nx;
   logic          ovf_nx;

   always_comb begin
      phase_nx = phase_in;
      stop_nx  = stop_in;
      acc_nx   = acc_in;
      ovf_nx   = ovf_in;
      if (take) begin
         if ((tbase < stoi_pkg::BASE_MIN) || !cls.digit_ok || (cls.digit_val >= tbase)) begin
            phase_nx = PH_STOP;
         end else begin
            phase_nx = PH_DIGITS;
            stop_nx  = count_in;
            if (!ovf_ff) begin
               if (prod > PROD_W'(limit)) begin
                  ovf_nx = 1'b1;
               end else begin
                  acc_nx = prod[VW-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      value = neg_in ? (VW'(0) - acc_nx) : acc_nx;
      priority if (!bs_ok) begin
         result.value_bits     = '0;
         result.consumed_count = '0;
         result.status         = stoi_pkg::ST_BAD_BASE;
      end else if (ovf_nx) begin
         if (cfg.signed_mode) begin
            result.value_bits = stoi_pkg::OUT_VALUE_W'(neg_in ? SMAX + 1'b1 : SMAX);
         end else begin
            result.value_bits = stoi_pkg::OUT_VALUE_W'(VMASK);
         end
         result.consumed_count = stoi_pkg::CONSUMED_W'(stop_nx);
         result.status         = stoi_pkg::ST_RANGE;
      end else begin
         result.value_bits     = stoi_pkg::OUT_VALUE_W'(value);
         result.consumed_count = stoi_pkg::CONSUMED_W'(stop_nx);
         result.status         = stoi_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
         stop_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_nx;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         acc_ff   <= acc_nx;
         ovf_ff   <= ovf_nx;
         count_ff <= count_in;
         stop_ff  <= stop_nx;
      end
   end

endmodule

`default_nettype wire

[hdl/string_to_integer_parser.sv]
// string to integer parser, top level: channels, registers, pipeline control
// depends on stoi_pkg and stoi_parse_core
//
// A string arrives on the req_ channel one character per request, req_tlast
// marking the final character. Each string yields exactly one response on the
// rsp_ channel, issued for the request that carries req_tlast; other requests
// yield none. The response holds the parsed value, the number of characters
// consumed and a status (ok, invalid base, out of range).
// Throughput: one character per cycle while the output is not stalled; the
// per-character multiply-add by the active base and overflow compare set it.
// A character sits in the input register, is folded into the parse state when
// the output is free and, if last, its result lands in the output register.
// When the receiver stalls, the held response stays stable; one more request
// can enter the input register and further requests wait on req_tready.
// The csr_ port writes base_select (index 0) and signed_mode (index 1); write
// only while no string is in flight.
// Reset (synchronous) clears the parse state and the valid flags of both
// pipeline registers and sets base_select to 10 and signed_mode to 0.
`default_nettype none

module string_to_integer_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,  // char_code
   input  wire logic                            req_tlast,  // last_char
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // value_bits [63:0], consumed_count [79:64], status [81:80], zero pad
   output      logic [stoi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [stoi_pkg::BASE_W-1:0]     csr_wdata
);

   stoi_pkg::cfg_type            cfg_ff;
   logic                         in_valid_ff, in_valid_in;
   logic [stoi_pkg::CHAR_W-1:0]  in_char_ff;
   logic                         in_last_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   stoi_pkg::result_type         rsp_ff;
   stoi_pkg::result_type         core_result;
   logic                         out_free;
   logic                         step;
   logic                         req_fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && in_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   stoi_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .cfg       (cfg_ff),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_select <= stoi_pkg::BASE_RESET;
         cfg_ff.signed_mode <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stoi_pkg::REG_BASE_SELECT: cfg_ff.base_select <= csr_wdata;
            stoi_pkg::REG_SIGNED_MODE: cfg_ff.signed_mode <= csr_wdata[0];
            default:                   cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = stoi_pkg::RSP_DATA_W'(rsp_ff);

endmodule

`default_nettype wire

[hdl/stoi_checker.sv]
// port-level checks for the string to integer parser, bound to the top level
// depends on stoi_pkg
`default_nettype none

module stoi_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [stoi_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [stoi_pkg::STATUS_W-1:0]   status;
   logic [stoi_pkg::CONSUMED_W-1:0] consumed;
   logic [stoi_pkg::OUT_VALUE_W-1:0] value;

   assign value    = rsp_tdata[63:0];
   assign consumed = rsp_tdata[79:64];
   assign status   = rsp_tdata[81:80];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status == stoi_pkg::ST_OK) || (status == stoi_pkg::ST_BAD_BASE) ||
                     (status == stoi_pkg::ST_RANGE))
      else $error("unknown status code");

   // invalid base reports nothing parsed
   a_bad_base_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == stoi_pkg::ST_BAD_BASE) |-> (value == '0) && (consumed == '0))
      else $error("invalid base with nonzero value or count");

   // no digit consumed means a zero value
   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == stoi_pkg::ST_OK) && (consumed == '0) |-> (value == '0))
      else $error("nonzero value with nothing consumed");

endmodule

bind string_to_integer_parser stoi_checker u_stoi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/sv/tb_string_to_integer_parser.sv]
// self-checking testbench for string_to_integer_parser: streams strings one character
// per request, predicts each response and checks it field by field
// depends on stoi_pkg and the parser RTL
`timescale 1ns / 100ps

module tb_string_to_integer_parser;
   import stoi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NOT_A_DIGIT    = 99;
   localparam int ROUND_CHARS    = 50;
   localparam int ROUNDS         = 16;

   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] SPACE_CODES [6] = '{CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR,
                                                     CH_SPACE};

   localparam logic [BASE_W-1:0] BAD_BASE_LOW  = 6'd1;
   localparam logic [BASE_W-1:0] BAD_BASE_HIGH = 6'd63;
   localparam logic [BASE_W-1:0] ROUND_BASES [8] = '{BASE_AUTO, BASE_MAX, BASE_MIN, BASE_HEX,
                                                     BAD_BASE_LOW, BAD_BASE_HIGH, BASE_OCT,
                                                     BASE_DEC};

   localparam logic [OUT_VALUE_W-1:0] UNSIGNED_MAX = '1;
   localparam logic [OUT_VALUE_W-1:0] SIGNED_MAX   = {1'b0, {(OUT_VALUE_W-1){1'b1}}};
   localparam logic [OUT_VALUE_W-1:0] SIGNED_MIN   = {1'b1, {(OUT_VALUE_W-1){1'b0}}};

   // sender gap and receiver stall, percent, per idling phase
   localparam int GAP_PCT [4]   = '{0, 65, 0, 6};
   localparam int STALL_PCT [4] = '{0, 0, 65, 6};

   typedef enum logic [2:0] {
      PH_SPACE, PH_SIGNED, PH_ZERO, PH_XPEND, PH_DIGITS, PH_STOP
   } parse_phase_type;

   class integer_parse_checker;
      logic [BASE_W-1:0]      base_sel;
      logic                   signed_on;
      parse_phase_type        phase;
      logic                   negative;
      logic [BASE_W-1:0]      radix;
      logic [OUT_VALUE_W-1:0] acc;
      logic                   overflow;
      logic [COUNT_WIDTH-1:0] seen;
      logic [COUNT_WIDTH-1:0] taken;
      result_type             pending_results[$];
      int                     mismatches;

      function new();
         base_sel = BASE_RESET;
         signed_on = 1'b0;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         phase = PH_SPACE;
         negative = 1'b0;
         radix = '0;
         acc = '0;
         overflow = 1'b0;
         seen = '0;
         taken = '0;
      endfunction

      function void write_reg(logic idx, logic [BASE_W-1:0] v);
         if (idx == REG_BASE_SELECT) begin
            base_sel = v;
         end else begin
            signed_on = v[0];
         end
      endfunction

      function bit radix_valid(logic [BASE_W-1:0] b);
         return b == BASE_AUTO || (b >= BASE_MIN && b <= BASE_MAX);
      endfunction

      function int char_weight(logic [CHAR_W-1:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
         if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_A + LETTER_OFS;
         if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c - CH_UPPER_A + LETTER_OFS;
         return NOT_A_DIGIT;
      endfunction

      function void take_digit(logic [CHAR_W-1:0] c);
         int d;
         logic [OUT_VALUE_W-1:0] limit;
         d = char_weight(c);
         if (radix < BASE_MIN || d >= radix) begin
            phase = PH_STOP;
            return;
         end
         phase = PH_DIGITS;
         taken = seen;
         if (!overflow) begin
            limit = signed_on ? (negative ? SIGNED_MIN : SIGNED_MAX) : UNSIGNED_MAX;
            if (acc > (limit - d) / radix) begin
               overflow = 1'b1;
            end else begin
               acc = acc * radix + d;
            end
         end
      endfunction

      function void note_char(logic [CHAR_W-1:0] c, logic last);
         result_type r;
         if (seen != {COUNT_WIDTH{1'b1}}) seen++;
         if (phase == PH_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            // leading whitespace, nothing to do
         end else if (phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
            negative = (c == CH_MINUS);
            phase = PH_SIGNED;
         end else if (phase == PH_SPACE || phase == PH_SIGNED) begin
            // base is latched here
            if (!radix_valid(base_sel)) begin
               phase = PH_STOP;
            end else if ((base_sel == BASE_AUTO || base_sel == BASE_HEX) && c == CH_ZERO) begin
               radix = (base_sel == BASE_HEX) ? BASE_HEX : BASE_OCT;
               taken = seen;
               phase = PH_ZERO;
            end else begin
               radix = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
               take_digit(c);
            end
         end else if (phase == PH_ZERO && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
            radix = BASE_HEX;
            phase = PH_XPEND;
         end else if (phase != PH_STOP) begin
            take_digit(c);
         end

         if (last) begin
            r.consumed_count = taken;
            r.status = ST_OK;
            if (!radix_valid(base_sel)) begin
               r.value_bits = '0;
               r.consumed_count = '0;
               r.status = ST_BAD_BASE;
            end else if (overflow) begin
               r.status = ST_RANGE;
               r.value_bits = signed_on ? (negative ? SIGNED_MIN : SIGNED_MAX) : UNSIGNED_MAX;
            end else begin
               r.value_bits = negative ? -acc : acc;
            end
            pending_results.push_back(r);
            clear();
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type want;
         logic [RSP_DATA_W-RSP_FIELDS_W-1:0] pad;
         got = data[RSP_FIELDS_W-1:0];
         pad = data[RSP_DATA_W-1:RSP_FIELDS_W];
         if (pending_results.size() == 0) begin
            flag($sformatf("response with no string pending: %h", data));
            return;
         end
         want = pending_results.pop_front();
         if (got.value_bits !== want.value_bits || got.consumed_count !== want.consumed_count ||
             got.status !== want.status || pad !== '0) begin
            flag($sformatf({"expected value %h count %0d status %0d, ",
                            "got value %h count %0d status %0d pad %h"},
                           want.value_bits, want.consumed_count, want.status,
                           got.value_bits, got.consumed_count, got.status, pad));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic                  csr_index  = REG_BASE_SELECT;
   logic [BASE_W-1:0]     csr_wdata  = '0;

   integer_parse_checker  sb = new();
   logic [CHAR_W-1:0]     text[$];
   int                    gap_pct;
   int                    stall_pct;
   int                    quiet_cycles;

   string_to_integer_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_string_to_integer_parser: errors");
         $finish;
      end
   end

   function automatic logic [CHAR_W-1:0] digit_char(int d, bit upper);
      if (d < LETTER_OFS) return CHAR_W'(CH_ZERO + d);
      return CHAR_W'((upper ? CH_UPPER_A : CH_LOWER_A) + d - LETTER_OFS);
   endfunction

   function automatic void add_text(string s);
      foreach (s[i]) text.push_back(s[i]);
   endfunction

   // digits of a value at, just below or just past the saturation limit of the current mode
   function automatic void add_boundary(int eb);
      logic [OUT_VALUE_W-1:0] target;
      logic [CHAR_W-1:0]      digits[$];
      bit                     neg;
      neg = 1'($urandom_range(1));
      if (sb.signed_on) begin
         target = neg ? SIGNED_MIN : SIGNED_MAX;
      end else begin
         target = UNSIGNED_MAX;
      end
      target = target - $urandom_range(2);
      if (sb.signed_on && $urandom_range(1)) target = target + $urandom_range(2, 1);
      if (neg) text.push_back(CH_MINUS);
      do begin
         digits.push_front(digit_char(int'(target % eb), 1'($urandom_range(1))));
         target = target / eb;
      end while (target != 0);
      text = {text, digits};
      if ($urandom_range(3) == 0) text.push_back(digit_char($urandom_range(eb - 1), 1'b0));
   endfunction

   function automatic void make_string();
      int kind;
      int eb;
      int n;
      logic [BASE_W-1:0] b;
      b = sb.base_sel;
      if (b >= BASE_MIN && b <= BASE_MAX) begin
         eb = b;
      end else if (b == BASE_AUTO) begin
         eb = BASE_DEC;
      end else begin
         eb = $urandom_range(36, 2);
      end
      kind = $urandom_range(99);
      if (kind < 10) begin
         // noise
         repeat ($urandom_range(8, 1)) text.push_back(CHAR_W'($urandom_range(255)));
      end else if (kind < 25) begin
         add_boundary(eb);
      end else begin
         repeat ($urandom_range(3)) text.push_back(SPACE_CODES[$urandom_range(5)]);
         case ($urandom_range(3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: ;
         endcase
         if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(2) != 0) begin
            text.push_back(CH_ZERO);
            if ($urandom_range(3) != 0) begin
               text.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
               eb = BASE_HEX;
            end else if (b == BASE_AUTO) begin
               eb = BASE_OCT;
            end
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(70, 10) : $urandom_range(8);
         repeat (n) text.push_back(digit_char($urandom_range(eb - 1), 1'($urandom_range(1))));
         if ($urandom_range(3) == 0) text.push_back(CHAR_W'($urandom_range(255)));
      end
      if (text.size() == 0) text.push_back(CHAR_W'($urandom_range(255)));
   endfunction

   task automatic send_text();
      int i;
      for (i = 0; i < text.size(); i++) begin
         while ($urandom_range(99) < gap_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= text[i];
         req_tlast  <= (i == text.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_char(text[i], i == text.size() - 1);
      end
      text.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [BASE_W-1:0] base_val, logic [BASE_W-1:0] mode_val);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= REG_BASE_SELECT;
      csr_wdata <= base_val;
      @(posedge clock);
      sb.write_reg(REG_BASE_SELECT, base_val);
      csr_index <= REG_SIGNED_MODE;
      csr_wdata <= mode_val;
      @(posedge clock);
      sb.write_reg(REG_SIGNED_MODE, mode_val);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int round;
      int sent;
      logic [BASE_W-1:0] base_val;
      gap_pct = GAP_PCT[3];
      stall_pct = STALL_PCT[3];
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unsigned decimal
      text.push_back(CH_NL);
      text.push_back(CH_CR);
      add_text("-7");
      send_text();
      add_text("x");
      send_text();
      text.push_back(CH_NUL);
      send_text();
      text.push_back(CH_VT);
      text.push_back(CH_FF);
      add_text(" +9");
      send_text();

      configure(BASE_AUTO, 6'd1);
      add_text("0x1F");
      send_text();
      add_text("0x");
      send_text();
      add_text("-017");
      send_text();
      configure(BASE_HEX, 6'd0);
      add_text("0XfF");
      send_text();
      configure(BASE_MAX, 6'd1);
      add_text("-Zz");
      send_text();
      configure(BASE_MIN, 6'd0);
      add_text("12");
      send_text();
      configure(BAD_BASE_LOW, 6'd0);
      add_text("5");
      send_text();
      configure(BAD_BASE_HIGH, 6'd63);
      add_text("7");
      send_text();

      for (round = 0; round < ROUNDS; round++) begin
         if (round < 8) begin
            base_val = ROUND_BASES[round];
            configure(base_val, {5'($urandom_range(31)), round[1]});
         end else begin
            base_val = BASE_W'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                        : $urandom_range(36));
            configure(base_val, 6'($urandom_range(63)));
         end
         gap_pct = GAP_PCT[round % 4];
         stall_pct = STALL_PCT[round % 4];
         sent = 0;
         while (sent < ROUND_CHARS) begin
            make_string();
            sent += text.size();
            send_text();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_string_to_integer_parser: clean");
      end else begin
         $display("tb_string_to_integer_parser: errors");
      end
      $finish;
   end

endmodule

[string_to_integer_parser.f]
hdl/stoi_pkg.sv
hdl/stoi_char_class.sv
hdl/stoi_parse_core.sv
hdl/string_to_integer_parser.sv
hdl/stoi_checker.sv
tb/sv/tb_string_to_integer_parser.sv
